// ===== rtl/mwfr_pkg.sv =====
// Package for the memoized window filter response block.
// Memory sizes, derived widths, command and register codes, sequencer states.
// No dependencies.
package mwfr_pkg;

    localparam int MAP_WORDS     = 65536;
    localparam int FILTER_WORDS  = 4096;
    localparam int CACHE_ENTRIES = 4096;

    localparam int MA_W  = $clog2(MAP_WORDS);
    localparam int FA_W  = $clog2(FILTER_WORDS);
    localparam int CA_W  = $clog2(CACHE_ENTRIES);
    // products are at most 2^30 in magnitude, up to FILTER_WORDS of them
    localparam int ACC_W = 33 + FA_W;
    // window word addresses fit 20 bits for any register contents
    localparam int WA_W  = 21;

    localparam int SCORE_W = 40;
    localparam int CFG_W   = 7;
    localparam int CIDX_W  = 3;

    typedef enum logic [1:0] {
        CMD_WR_MAP = 2'd0,
        CMD_WR_FLT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [CIDX_W-1:0] REG_MAP_W   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FEAT    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_FLT_W   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_FLT_H   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_STRIDE  = 3'd4;

    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CHK1  = 8'b0000_0100,
        S_CHK2  = 8'b0000_1000,
        S_CHK3  = 8'b0001_0000,
        S_RUN   = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/mwfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/memoized_window_filter_response.sv =====
// Top level of the memoized window filter response block.
// Uses mwfr_pkg and three mwfr_ram instances (map, weights, score cache).
//
// channel  | valid    | stall    | payload
// input    | i_valid  | o_stall  | i_cmd i_addr i_value i_col i_row
// output   | o_valid  | i_stall  | o_score o_from_cache o_window_error
// config   | i_cfg_we | -        | i_cfg_idx i_cfg_data
//
// A query passes S_CHK1, S_CHK2 and S_CHK3 for bounds checks and the cache
// lookup, then S_RUN and S_DRAIN on a miss: one multiply-accumulate per cycle
// through the shared MAC, limited by the single read port of each memory. A
// clear sweeps the cache; the same sweep runs after reset. Results wait in an
// output register; the next item is taken while one waits, a finished query
// waits for it to free.
module memoized_window_filter_response (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_cmd,
    input  logic [15:0]                 i_addr,
    input  logic signed [15:0]          i_value,
    input  logic [5:0]                  i_col,
    input  logic [5:0]                  i_row,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [39:0]          o_score,
    output logic                        o_from_cache,
    output logic                        o_window_error,
    input  logic                        i_cfg_we,
    input  logic [mwfr_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [mwfr_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int MA_W  = mwfr_pkg::MA_W;
    localparam int FA_W  = mwfr_pkg::FA_W;
    localparam int CA_W  = mwfr_pkg::CA_W;
    localparam int ACC_W = mwfr_pkg::ACC_W;
    localparam int WA_W  = mwfr_pkg::WA_W;

    mwfr_pkg::t_state r_state, n_state;

    logic [6:0] r_w, r_s;
    logic [5:0] r_f;
    logic [4:0] r_fw, r_fh;

    logic [5:0]  r_col, r_row;
    logic [12:0] r_a, r_wf;
    logic [10:0] r_rowlen;
    logic [9:0]  r_nw1;
    logic [13:0] r_pos, r_t1;
    logic [WA_W-1:0] r_base, r_last;
    logic [15:0] r_nw;

    logic [WA_W-1:0] r_ma, r_mrow;
    logic [FA_W-1:0] r_wa;
    logic [10:0]     r_k;
    logic [4:0]      r_v;
    logic            r_p1, r_p2;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic [CA_W-1:0] r_clr;
    logic [39:0]     r_res_score;
    logic            r_res_hit, r_res_err, r_res_wr;

    logic        r_ov, r_hit, r_err;
    logic [39:0] r_score;

    logic        in_acc, out_free, last_issue, err, sat_ovf;
    logic [15:0] map_q, flt_q;
    logic [40:0] cache_q;
    logic        cache_we;
    logic [CA_W-1:0] cache_waddr;
    logic [40:0] cache_wdata;
    logic [39:0] sat_score;

    assign in_acc   = i_valid && (r_state == mwfr_pkg::S_IDLE);
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != mwfr_pkg::S_IDLE);

    mwfr_ram #(.WIDTH(16), .DEPTH(mwfr_pkg::MAP_WORDS)) u_map (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_cmd == mwfr_pkg::CMD_WR_MAP
                  && 32'(i_addr) < mwfr_pkg::MAP_WORDS),
        .i_waddr (MA_W'(i_addr)),
        .i_wdata (i_value),
        .i_raddr (r_ma[MA_W-1:0]),
        .o_rdata (map_q)
    );

    mwfr_ram #(.WIDTH(16), .DEPTH(mwfr_pkg::FILTER_WORDS)) u_flt (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_cmd == mwfr_pkg::CMD_WR_FLT
                  && 32'(i_addr) < mwfr_pkg::FILTER_WORDS),
        .i_waddr (FA_W'(i_addr)),
        .i_wdata (i_value),
        .i_raddr (r_wa),
        .o_rdata (flt_q)
    );

    // cache word: {valid, score}; the sweep writes zeros
    assign cache_we    = (r_state == mwfr_pkg::S_CLR)
                         || (r_state == mwfr_pkg::S_DONE && out_free && r_res_wr);
    assign cache_waddr = (r_state == mwfr_pkg::S_CLR) ? r_clr : r_pos[CA_W-1:0];
    assign cache_wdata = (r_state == mwfr_pkg::S_CLR) ? 41'd0 : {1'b1, r_res_score};

    mwfr_ram #(.WIDTH(41), .DEPTH(mwfr_pkg::CACHE_ENTRIES)) u_cache (
        .i_clk   (i_clk),
        .i_we    (cache_we),
        .i_waddr (cache_waddr),
        .i_wdata (cache_wdata),
        .i_raddr (r_pos[CA_W-1:0]),
        .o_rdata (cache_q)
    );

    assign err = (r_w == 7'd0) || (r_f == 6'd0) || (r_fw == 5'd0) || (r_fh == 5'd0)
                 || (r_s == 7'd0)
                 || ({1'b0, r_col} + {2'b0, r_fw} > r_w)
                 || ({1'b0, r_col} >= r_s)
                 || (32'(r_last) > mwfr_pkg::MAP_WORDS)
                 || (32'(r_nw) > mwfr_pkg::FILTER_WORDS)
                 || (32'(r_pos) >= mwfr_pkg::CACHE_ENTRIES);

    assign last_issue = (r_v == r_fh - 5'd1) && (r_k == r_rowlen - 11'd1);

    assign sat_ovf   = (r_acc[ACC_W-1:39] != {(ACC_W-39){r_acc[ACC_W-1]}});
    assign sat_score = !sat_ovf ? r_acc[39:0]
                     : (r_acc[ACC_W-1] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mwfr_pkg::S_CLR: begin
                if (r_clr == CA_W'(mwfr_pkg::CACHE_ENTRIES - 1)) n_state = mwfr_pkg::S_IDLE;
            end
            mwfr_pkg::S_IDLE: begin
                if (in_acc && i_cmd == mwfr_pkg::CMD_QUERY) n_state = mwfr_pkg::S_CHK1;
                else if (in_acc && i_cmd == mwfr_pkg::CMD_CLEAR) n_state = mwfr_pkg::S_CLR;
            end
            mwfr_pkg::S_CHK1: n_state = mwfr_pkg::S_CHK2;
            mwfr_pkg::S_CHK2: n_state = mwfr_pkg::S_CHK3;
            mwfr_pkg::S_CHK3: begin
                if (err || cache_q[40]) n_state = mwfr_pkg::S_DONE;
                else n_state = mwfr_pkg::S_RUN;
            end
            mwfr_pkg::S_RUN: begin
                if (last_issue) n_state = mwfr_pkg::S_DRAIN;
            end
            mwfr_pkg::S_DRAIN: begin
                if (!r_p1 && !r_p2) n_state = mwfr_pkg::S_DONE;
            end
            mwfr_pkg::S_DONE: begin
                if (out_free) n_state = mwfr_pkg::S_IDLE;
            end
            default: n_state = mwfr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwfr_pkg::S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
            r_w     <= 7'd64;
            r_f     <= 6'd31;
            r_fw    <= 5'd6;
            r_fh    <= 5'd6;
            r_s     <= 7'd64;
        end else begin
            r_state <= n_state;
            if (r_state == mwfr_pkg::S_CLR) r_clr <= r_clr + CA_W'(1);
            else r_clr <= '0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mwfr_pkg::REG_MAP_W:  r_w  <= i_cfg_data;
                    mwfr_pkg::REG_FEAT:   r_f  <= i_cfg_data[5:0];
                    mwfr_pkg::REG_FLT_W:  r_fw <= i_cfg_data[4:0];
                    mwfr_pkg::REG_FLT_H:  r_fh <= i_cfg_data[4:0];
                    mwfr_pkg::REG_STRIDE: r_s  <= i_cfg_data;
                    default: ;
                endcase
            end

            r_p1 <= (r_state == mwfr_pkg::S_RUN);
            r_p2 <= r_p1;

            if (r_state == mwfr_pkg::S_DONE && out_free) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col <= i_col;
            r_row <= i_row;
        end
        // r_last is compared as (exclusive end) > MAP_WORDS
        r_a      <= 13'(r_row) * 13'(r_w);
        r_wf     <= 13'(r_w) * 13'(r_f);
        r_rowlen <= 11'(r_fw) * 11'(r_f);
        r_nw1    <= 10'(r_fh) * 10'(r_fw);
        r_pos    <= 14'(r_row) * 14'(r_s) + 14'(r_col);
        r_t1     <= (14'(r_row) + 14'(r_fh) - 14'd1) * 14'(r_w);
        r_base   <= (WA_W'(r_a) + WA_W'(r_col)) * WA_W'(r_f);
        r_last   <= (WA_W'(r_t1) + WA_W'(r_col) + WA_W'(r_fw)) * WA_W'(r_f);
        r_nw     <= 16'(r_nw1) * 16'(r_f);

        r_prod <= $signed(map_q) * $signed(flt_q);

        case (r_state)
            mwfr_pkg::S_CHK3: begin
                r_ma   <= r_base;
                r_mrow <= r_base;
                r_wa   <= '0;
                r_k    <= '0;
                r_v    <= '0;
                r_acc  <= '0;
                r_res_score <= err ? 40'd0 : cache_q[39:0];
                r_res_hit   <= !err;
                r_res_err   <= err;
                r_res_wr    <= 1'b0;
            end
            mwfr_pkg::S_RUN: begin
                r_wa <= r_wa + FA_W'(1);
                if (r_k == r_rowlen - 11'd1) begin
                    r_k    <= '0;
                    r_v    <= r_v + 5'd1;
                    r_mrow <= r_mrow + WA_W'(r_wf);
                    r_ma   <= r_mrow + WA_W'(r_wf);
                end else begin
                    r_k  <= r_k + 11'd1;
                    r_ma <= r_ma + WA_W'(1);
                end
                if (r_p2) r_acc <= r_acc + ACC_W'(r_prod);
            end
            mwfr_pkg::S_DRAIN: begin
                if (r_p2) r_acc <= r_acc + ACC_W'(r_prod);
                r_res_score <= sat_score;
                r_res_hit   <= 1'b0;
                r_res_err   <= 1'b0;
                r_res_wr    <= 1'b1;
            end
            default: ;
        endcase

        if (r_state == mwfr_pkg::S_DONE && out_free) begin
            r_score <= r_res_score;
            r_hit   <= r_res_hit;
            r_err   <= r_res_err;
        end
    end

    assign o_valid        = r_ov;
    assign o_score        = r_score;
    assign o_from_cache   = r_hit;
    assign o_window_error = r_err;

endmodule

// ===== rtl/mwfr_checker.sv =====
// Port-level assertions for memoized_window_filter_response, bound to the top.
// Uses mwfr_pkg for command codes.
module mwfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_cmd,
    input logic        o_valid,
    input logic        i_stall,
    input logic [39:0] o_score,
    input logic        o_from_cache,
    input logic        o_window_error
);

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_score)
                               && $stable(o_from_cache) && $stable(o_window_error))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_window_error |-> o_score == 40'd0 && !o_from_cache)
        else $error("error result not zero");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == mwfr_pkg::CMD_QUERY || i_cmd == mwfr_pkg::CMD_CLEAR)
        |=> o_stall)
        else $error("query or clear transfer did not make block busy");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_cmd == mwfr_pkg::CMD_QUERY && !(o_valid && i_stall)
        |=> !o_valid || !$changed(o_score) || !$rose(o_valid))
        else $error("result appeared the cycle after a query");

endmodule

bind memoized_window_filter_response mwfr_checker u_mwfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_cmd          (i_cmd),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_score        (o_score),
    .o_from_cache   (o_from_cache),
    .o_window_error (o_window_error)
);

// ===== test/tb_memoized_window_filter_response.sv =====
// Testbench for memoized_window_filter_response: queued random and directed items,
// a scoring model of the window filter with its result cache, checked per field.
// Depends on rtl/mwfr_pkg.sv and rtl/memoized_window_filter_response.sv.
`timescale 1ns / 100ps

module tb_memoized_window_filter_response;

    typedef struct {
        mwfr_pkg::t_cmd cmd;
        logic [15:0]    addr;
        logic [15:0]    value;
        logic [5:0]     col;
        logic [5:0]     row;
    } t_item;

    typedef struct {
        logic signed [39:0] score;
        logic               hit;
        logic               err;
    } t_score;

    localparam longint SCORE_MAX = 64'sd549755813887;
    localparam longint SCORE_MIN = -64'sd549755813888;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [1:0]                   i_cmd = '0;
    logic [15:0]                  i_addr = '0;
    logic signed [15:0]           i_value = '0;
    logic [5:0]                   i_col = '0;
    logic [5:0]                   i_row = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic signed [39:0]           o_score;
    logic                         o_from_cache;
    logic                         o_window_error;
    logic                         i_cfg_we = 1'b0;
    logic [mwfr_pkg::CIDX_W-1:0]  i_cfg_idx = '0;
    logic [mwfr_pkg::CFG_W-1:0]   i_cfg_data = '0;

    memoized_window_filter_response uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state
    int                 cfg_mw = 64, cfg_f = 31, cfg_fw = 6, cfg_fh = 6, cfg_st = 64;
    logic signed [15:0] map_mem [mwfr_pkg::MAP_WORDS];
    logic signed [15:0] flt_mem [mwfr_pkg::FILTER_WORDS];
    logic signed [39:0] memo [mwfr_pkg::CACHE_ENTRIES];
    bit                 memo_ok [mwfr_pkg::CACHE_ENTRIES];
    bit                 map_set [mwfr_pkg::MAP_WORDS];
    bit                 flt_set [mwfr_pkg::FILTER_WORDS];

    t_item  pend_q [$];
    t_score score_q [$];
    int     errs = 0;
    bit     idle_on = 1'b1;
    bit     hold_req = 1'b0;
    bit     hold_done = 1'b0;
    int     hold_cnt = 0;
    int     gap_left = 0;
    int     stall_left = 0;

    function automatic bit window_bad(int col, int row);
        longint last_word;
        if (cfg_mw == 0 || cfg_f == 0 || cfg_fw == 0 || cfg_fh == 0 || cfg_st == 0 ||
            col + cfg_fw > cfg_mw || col >= cfg_st)
            return 1'b1;
        last_word = (longint'(row + cfg_fh - 1) * cfg_mw + col + cfg_fw) * cfg_f - 1;
        return last_word >= mwfr_pkg::MAP_WORDS ||
               cfg_fh * cfg_fw * cfg_f > mwfr_pkg::FILTER_WORDS ||
               row * cfg_st + col >= mwfr_pkg::CACHE_ENTRIES;
    endfunction

    task automatic apply_item(t_item it);
        t_score r;
        longint acc;
        int     pos, mbase, wbase;
        r = '{0, 1'b0, 1'b0};
        case (it.cmd)
            mwfr_pkg::CMD_WR_MAP: map_mem[it.addr] = it.value;
            mwfr_pkg::CMD_WR_FLT: begin
                if (it.addr < mwfr_pkg::FILTER_WORDS) flt_mem[it.addr] = it.value;
            end
            mwfr_pkg::CMD_CLEAR:  memo_ok = '{default: 1'b0};
            default: begin
                if (window_bad(it.col, it.row)) begin
                    r.err = 1'b1;
                end else begin
                    pos = it.row * cfg_st + it.col;
                    if (memo_ok[pos]) begin
                        r.score = memo[pos];
                        r.hit = 1'b1;
                    end else begin
                        acc = 0;
                        for (int v = 0; v < cfg_fh; v++) begin
                            mbase = ((it.row + v) * cfg_mw + it.col) * cfg_f;
                            wbase = v * cfg_fw * cfg_f;
                            for (int k = 0; k < cfg_fw * cfg_f; k++)
                                acc += longint'(map_mem[mbase + k])
                                       * longint'(flt_mem[wbase + k]);
                        end
                        if (acc > SCORE_MAX) acc = SCORE_MAX;
                        if (acc < SCORE_MIN) acc = SCORE_MIN;
                        memo[pos] = acc[39:0];
                        memo_ok[pos] = 1'b1;
                        r.score = acc[39:0];
                    end
                end
                score_q.push_back(r);
            end
        endcase
    endtask

    // sender
    always @(posedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                nxt = '{mwfr_pkg::t_cmd'(i_cmd), i_addr, i_value, i_col, i_row};
                apply_item(nxt);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    nxt = pend_q.pop_front();
                    i_valid <= 1'b1;
                    i_cmd <= nxt.cmd;
                    i_addr <= nxt.addr;
                    i_value <= nxt.value;
                    i_col <= nxt.col;
                    i_row <= nxt.row;
                    if (idle_on && $urandom_range(0, 99) < 12)
                        gap_left = $urandom_range(1, 10);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic flag(string what, t_score e, t_score a);
        errs++;
        if (errs <= 10)
            $display("mismatch %0s: exp score %0d hit %0b err %0b, got score %0d hit %0b err %0b",
                     what, e.score, e.hit, e.err, a.score, a.hit, a.err);
    endtask

    // receiver and checker
    always @(posedge i_clk) begin
        t_score got, want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_score, o_from_cache, o_window_error};
                if (score_q.size() == 0) begin
                    flag("unexpected transfer", '{0, 1'b0, 1'b0}, got);
                end else begin
                    want = score_q.pop_front();
                    if (got.score !== want.score) flag("score", want, got);
                    if (got.hit !== want.hit) flag("from_cache", want, got);
                    if (got.err !== want.err) flag("window_error", want, got);
                end
            end
            if (hold_req && !hold_done) begin
                // long back-pressure so the block fills and stalls its input
                if (hold_cnt == 400) begin
                    hold_done <= 1'b1;
                    i_stall <= 1'b0;
                end else begin
                    hold_cnt++;
                    i_stall <= 1'b1;
                end
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 99) < 12) begin
                stall_left = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic add(mwfr_pkg::t_cmd c, int a, int val, int cl, int rw);
        pend_q.push_back('{c, a[15:0], val[15:0], cl[5:0], rw[5:0]});
        if (c == mwfr_pkg::CMD_WR_MAP) map_set[a[15:0]] = 1'b1;
        if (c == mwfr_pkg::CMD_WR_FLT && a[15:0] < mwfr_pkg::FILTER_WORDS)
            flt_set[a[15:0]] = 1'b1;
    endtask

    // write any word the window reads that holds no value yet
    task automatic fill_window(int col, int row);
        int ma, wa;
        for (int v = 0; v < cfg_fh; v++)
            for (int k = 0; k < cfg_fw * cfg_f; k++) begin
                ma = ((row + v) * cfg_mw + col) * cfg_f + k;
                wa = v * cfg_fw * cfg_f + k;
                if (!map_set[ma])
                    add(mwfr_pkg::CMD_WR_MAP, ma, $urandom_range(0, 65535), 0, 0);
                if (!flt_set[wa])
                    add(mwfr_pkg::CMD_WR_FLT, wa, $urandom_range(0, 65535), 0, 0);
            end
    endtask

    task automatic query(int col, int row);
        if (!window_bad(col, row)) fill_window(col, row);
        add(mwfr_pkg::CMD_QUERY, $urandom_range(0, 65535), $urandom_range(0, 65535),
            col, row);
    endtask

    task automatic settle(int extra);
        do @(negedge i_clk);
        while (pend_q.size() != 0 || i_valid || score_q.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [mwfr_pkg::CIDX_W-1:0] idx, int data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[mwfr_pkg::CFG_W-1:0];
        case (idx)
            mwfr_pkg::REG_MAP_W:  cfg_mw = data & 'h7f;
            mwfr_pkg::REG_FEAT:   cfg_f = data & 'h3f;
            mwfr_pkg::REG_FLT_W:  cfg_fw = data & 'h1f;
            mwfr_pkg::REG_FLT_H:  cfg_fh = data & 'h1f;
            mwfr_pkg::REG_STRIDE: cfg_st = data & 'h7f;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(int mw, int f, int fw, int fh, int st);
        settle(4200);   // covers a cache sweep still running after the last result
        write_reg(mwfr_pkg::REG_MAP_W, mw);
        write_reg(mwfr_pkg::REG_FEAT, f);
        write_reg(mwfr_pkg::REG_FLT_W, fw);
        write_reg(mwfr_pkg::REG_FLT_H, fh);
        write_reg(mwfr_pkg::REG_STRIDE, st);
    endtask

    task automatic random_mix(int n);
        int r, cl;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 14) begin
                if (r < 5)
                    add(mwfr_pkg::CMD_WR_MAP, $urandom_range(0, 65535),
                        $urandom_range(0, 65535), 0, 0);
                else
                    add(mwfr_pkg::CMD_WR_MAP, $urandom_range(0, 255),
                        $urandom_range(0, 65535), 0, 0);
            end else if (r < 22) begin
                if (r < 16)
                    add(mwfr_pkg::CMD_WR_FLT, $urandom_range(0, 65535),
                        $urandom_range(0, 65535), 0, 0);
                else
                    add(mwfr_pkg::CMD_WR_FLT, $urandom_range(0, 63),
                        $urandom_range(0, 65535), 0, 0);
            end else if (r < 26) begin
                add(mwfr_pkg::CMD_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 63), $urandom_range(0, 63));
            end else if (r < 38) begin
                query($urandom_range(0, 63), $urandom_range(0, 63));
            end else begin
                // small region of positions so repeats hit the cache
                cl = (cfg_mw >= cfg_fw) ? cfg_mw - cfg_fw : 0;
                if (cl > 7) cl = 7;
                query($urandom_range(0, cl), $urandom_range(0, 3));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: window past the right edge, and a clear
        settle(4200);
        query(60, 0);
        add(mwfr_pkg::CMD_CLEAR, 0, 0, 0, 0);

        // directed, small window
        setup(4, 2, 2, 2, 4);
        query(3, 0);
        query(0, 0);
        query(0, 0);
        add(mwfr_pkg::CMD_WR_MAP, 0, 16'h7fff, 0, 0);     // stale: cached score kept
        query(0, 0);
        add(mwfr_pkg::CMD_CLEAR, 0, 0, 0, 0);
        query(0, 0);
        add(mwfr_pkg::CMD_WR_FLT, 4096, 16'h1234, 0, 0);  // ignored, past weight store
        add(mwfr_pkg::CMD_WR_FLT, 65535, 16'h8000, 0, 0);
        add(mwfr_pkg::CMD_WR_MAP, 65535, 16'h8000, 0, 0);
        query(0, 63);
        query(2, 63);
        query(63, 63);

        // full-scale products: large positive and large negative sums
        setup(4, 4, 4, 1, 4);
        for (int a = 0; a < 32; a++)
            add(mwfr_pkg::CMD_WR_MAP, a, (a < 16) ? 16'h8000 : 16'h7fff, 0, 0);
        for (int a = 0; a < 16; a++) add(mwfr_pkg::CMD_WR_FLT, a, 16'h8000, 0, 0);
        query(0, 0);
        query(0, 1);
        query(0, 0);

        setup(8, 2, 2, 2, 8);
        hold_req <= 1'b1;
        random_mix(45);
        setup(1, 1, 1, 1, 1);
        random_mix(30);
        setup(16, 1, 4, 1, 16);
        random_mix(35);
        setup(5, 2, 1, 1, 64);
        random_mix(30);
        setup(20, 1, 2, 2, 10);
        random_mix(30);
        setup(100, 1, 3, 1, 127);
        random_mix(25);
        setup(0, 0, 0, 0, 0);
        random_mix(15);
        setup(8, 1, 2, 3, 8);
        random_mix(35);
        setup(12, 1, 3, 2, 12);
        idle_on <= 1'b0;
        random_mix(35);

        settle(50);
        if (errs == 0 && score_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule
